@@ rtl/lrupr_pkg.sv @@
// Shared constants and types for the LRU page replacement stack.
package lrupr_pkg;

  localparam int MAX_FRAMES_DEF = 32;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int PAGE_W         = 16;
  localparam int COUNT_W        = 32;
  localparam int FRAME_W        = 6;

  localparam logic [FRAME_W-1:0] FRAME_COUNT_RESET = FRAME_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;

  typedef struct packed {
    logic step;
    logic hit;
    logic evict;
  } lru_ctrl_t;

endpackage

@@ rtl/lrupr_if.sv @@
// Valid/ready channel interfaces for page references and replacement results.
interface lrupr_in_if
  import lrupr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lrupr_out_if
  import lrupr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               fault;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [COUNT_W-1:0] fault_total;
  logic [COUNT_W-1:0] reference_total;

  modport source (output valid, output fault, output evicted_valid, output evicted_page,
                  output fault_total, output reference_total, input ready);
  modport sink   (input valid, input fault, input evicted_valid, input evicted_page,
                  input fault_total, input reference_total, output ready);
endinterface

@@ rtl/lrupr_cell.sv @@
// One position of the recency stack: holds a page, compares it and shifts toward the LRU end.
module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int OCC_W     = 6,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  lru_ctrl_t            ctrl,
  input  logic [OCC_W-1:0]     occ,
  input  logic [PAGE_BITS-1:0] pg,
  input  logic [PAGE_BITS-1:0] upper_page,
  input  logic                 prefix_in,
  output logic                 prefix_out,
  output logic [PAGE_BITS-1:0] page_out
);

  localparam logic [OCC_W-1:0] POS      = OCC_W'(IDX);
  localparam logic [OCC_W:0]   NEXT_POS = (OCC_W+1)'(IDX + 1);

  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] page_nxt;
  logic                 occupied;
  logic                 below_top;
  logic                 is_top;
  logic                 is_append;

  assign occupied   = POS < occ;
  assign below_top  = NEXT_POS < {1'b0, occ};
  assign is_top     = NEXT_POS == {1'b0, occ};
  assign is_append  = POS == occ;
  assign prefix_out = prefix_in | (occupied && (page_r == pg));
  assign page_out   = page_r;

  always_comb begin
    page_nxt = page_r;
    if (ctrl.step) begin
      if (below_top && (prefix_out || ctrl.evict)) begin
        page_nxt = upper_page;
      end else if (is_top && (ctrl.hit || ctrl.evict)) begin
        page_nxt = pg;
      end else if (is_append && !ctrl.hit && !ctrl.evict) begin
        page_nxt = pg;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule

@@ rtl/lru_page_replacement.sv @@
// Top level of the LRU page replacement stack with fault and reference counters.
//
// The in_ch channel takes one page reference per item; out_ch returns one result
// item per reference: fault, evicted_valid, evicted_page and the running fault and
// reference totals, both saturating. cfg_we with cfg_wdata sets frame_count, the
// number of frames in use; 0 acts as 1 and values above MAX_FRAMES act as MAX_FRAMES.
// The stack is a row of MAX_FRAMES cells. All cells compare the reference in
// parallel and a match flag ripples from the LRU end, so a hit, append or eviction
// and the shift of the stack complete in the cycle the item is accepted.
// The result is registered in the output register when the item is accepted, and one
// item is taken per cycle as long as out_ch is ready. When the receiver stalls,
// the output register holds its item and in_ch.ready drops until it is taken.
// Reset empties the stack (occupancy zero), clears both counters and sets
// frame_count to 4; no clearing pass is needed and items are taken right away.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [FRAME_W-1:0] cfg_wdata,
  lrupr_in_if.sink           in_ch,
  lrupr_out_if.source        out_ch
);

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);
  localparam logic [OCC_W-1:0] OCC_MAX = OCC_W'(MAX_FRAMES);

  logic [FRAME_W-1:0]   frame_count_r;
  logic [OCC_W-1:0]     occ_r;
  logic [OCC_W-1:0]     occ_nxt;
  logic [OCC_W-1:0]     limit;
  logic [COUNT_W-1:0]   fault_cnt_r;
  logic [COUNT_W-1:0]   fault_cnt_nxt;
  logic [COUNT_W-1:0]   ref_cnt_r;
  logic [COUNT_W-1:0]   ref_cnt_nxt;
  logic                 out_valid_r;
  logic                 fault_r;
  logic                 evicted_valid_r;
  logic [PAGE_W-1:0]    evicted_page_r;
  logic [PAGE_W-1:0]    evicted_page_nxt;
  logic                 accept;
  logic                 hit;
  logic                 evict;
  lru_ctrl_t            ctrl;
  logic [PAGE_BITS+PAGE_W-1:0] pg_ext;
  logic [PAGE_BITS+PAGE_W-1:0] ev_ext;
  logic [PAGE_BITS-1:0] pg;
  logic [MAX_FRAMES:0]  prefix;
  logic [PAGE_BITS-1:0] cell_page [MAX_FRAMES];

  assign pg_ext = {{PAGE_BITS{1'b0}}, in_ch.page_number};
  assign pg     = pg_ext[PAGE_BITS-1:0];

  always_comb begin
    if (frame_count_r == '0) begin
      limit = OCC_W'(1);
    end else if (32'(frame_count_r) > 32'(MAX_FRAMES)) begin
      limit = OCC_MAX;
    end else begin
      limit = OCC_W'(frame_count_r);
    end
  end

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign hit         = prefix[MAX_FRAMES];
  assign evict       = !hit && (occ_r >= limit);
  assign ctrl        = '{step: accept, hit: hit, evict: evict};
  assign prefix[0]   = 1'b0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    logic [PAGE_BITS-1:0] upper;
    if (i == MAX_FRAMES - 1) begin : g_last
      assign upper = pg;
    end else begin : g_mid
      assign upper = cell_page[i+1];
    end
    lrupr_cell #(
      .IDX       (i),
      .OCC_W     (OCC_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ_r),
      .pg         (pg),
      .upper_page (upper),
      .prefix_in  (prefix[i]),
      .prefix_out (prefix[i+1]),
      .page_out   (cell_page[i])
    );
  end

  assign ev_ext = {{PAGE_W{1'b0}}, cell_page[0]};

  always_comb begin
    occ_nxt          = occ_r;
    fault_cnt_nxt    = fault_cnt_r;
    ref_cnt_nxt      = (ref_cnt_r == COUNT_MAX) ? ref_cnt_r : ref_cnt_r + COUNT_W'(1);
    evicted_page_nxt = evict ? ev_ext[PAGE_W-1:0] : '0;
    if (!hit) begin
      fault_cnt_nxt = (fault_cnt_r == COUNT_MAX) ? fault_cnt_r : fault_cnt_r + COUNT_W'(1);
      if (!evict) begin
        occ_nxt = occ_r + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_COUNT_RESET;
      occ_r         <= '0;
      fault_cnt_r   <= '0;
      ref_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
      if (accept) begin
        occ_r       <= occ_nxt;
        fault_cnt_r <= fault_cnt_nxt;
        ref_cnt_r   <= ref_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fault_r         <= !hit;
      evicted_valid_r <= evict;
      evicted_page_r  <= evicted_page_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.fault           = fault_r;
  assign out_ch.evicted_valid   = evicted_valid_r;
  assign out_ch.evicted_page    = evicted_page_r;
  assign out_ch.fault_total     = fault_cnt_r;
  assign out_ch.reference_total = ref_cnt_r;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the LRU page replacement stack.
`timescale 1ns / 1ps

module tb;
  import lrupr_pkg::*;

  localparam int FRAMES = MAX_FRAMES_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_PER_SETTING = 150;

  typedef struct packed {
    logic               fault;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_total;
    logic [COUNT_W-1:0] reference_total;
  } lru_result_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_HELD_LOW} ready_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [FRAME_W-1:0] cfg_wdata;

  lrupr_in_if  in_ch ();
  lrupr_out_if out_ch ();

  lru_page_replacement dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [PAGE_W-1:0]  resident_pages [FRAMES];
  int                 occupied;
  logic [COUNT_W-1:0] faults_total;
  logic [COUNT_W-1:0] refs_total;
  logic [FRAME_W-1:0] frame_setting;

  logic [PAGE_W-1:0] page_q [$];
  lru_result_t       expected_results [$];

  int  mismatch_count = 0;
  int  checked_count = 0;
  int  hit_count = 0;
  int  evict_count = 0;
  int  idle_cycles = 0;
  bit  item_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;

  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          ready_period = 2;
  int          ready_tick = 0;

  function automatic int effective_frames();
    if (int'(frame_setting) == 0) return 1;
    if (int'(frame_setting) > FRAMES) return FRAMES;
    return int'(frame_setting);
  endfunction

  task automatic apply_reference(input logic [PAGE_W-1:0] page);
    lru_result_t res;
    int          slot;
    int          limit;
    res = '0;
    slot = -1;
    limit = effective_frames();
    for (int k = 0; k < occupied; k++) begin
      if (slot < 0 && resident_pages[k] == page) slot = k;
    end
    if (slot >= 0) begin
      for (int i = slot; i + 1 < occupied; i++) resident_pages[i] = resident_pages[i + 1];
      resident_pages[occupied - 1] = page;
    end else begin
      res.fault = 1'b1;
      faults_total = (faults_total == COUNT_MAX) ? faults_total : faults_total + COUNT_W'(1);
      if (occupied < limit) begin
        resident_pages[occupied] = page;
        occupied++;
      end else begin
        res.evicted_valid = 1'b1;
        res.evicted_page = resident_pages[0];
        for (int i = 0; i + 1 < occupied; i++) resident_pages[i] = resident_pages[i + 1];
        resident_pages[occupied - 1] = page;
      end
    end
    refs_total = (refs_total == COUNT_MAX) ? refs_total : refs_total + COUNT_W'(1);
    res.fault_total = faults_total;
    res.reference_total = refs_total;
    expected_results.push_back(res);
  endtask

  task automatic report_field(input string field, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  // Result checking first, so that a result leaving in the same cycle meets its own item.
  always @(posedge clk) begin
    lru_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result item arrived with nothing expected", $time);
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (!want.fault) hit_count++;
          if (want.evicted_valid) evict_count++;
          if (out_ch.fault !== want.fault)
            report_field("fault", COUNT_W'(want.fault), COUNT_W'(out_ch.fault));
          if (out_ch.evicted_valid !== want.evicted_valid)
            report_field("evicted_valid", COUNT_W'(want.evicted_valid),
                         COUNT_W'(out_ch.evicted_valid));
          if (out_ch.evicted_page !== want.evicted_page)
            report_field("evicted_page", COUNT_W'(want.evicted_page),
                         COUNT_W'(out_ch.evicted_page));
          if (out_ch.fault_total !== want.fault_total)
            report_field("fault_total", want.fault_total, out_ch.fault_total);
          if (out_ch.reference_total !== want.reference_total)
            report_field("reference_total", want.reference_total, out_ch.reference_total);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_reference(in_ch.page_number);
        void'(page_q.pop_front());
        item_taken = 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!in_ch.valid || item_taken) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (page_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.page_number <= page_q[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left = (ready_mode == READY_HELD_LOW) ? $urandom_range(3, 30) : $urandom_range(20, 150);
      ready_period = $urandom_range(2, 6);
    end else begin
      mode_left--;
    end
    ready_tick++;
    case (ready_mode)
      READY_ALWAYS:   out_ch.ready <= 1'b1;
      READY_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
      READY_PERIODIC: out_ch.ready <= (ready_tick % ready_period == 0);
      default:        out_ch.ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("lru_page_replacement verification failed");
      $finish;
    end
  end

  task automatic wait_for_drain();
    while (page_q.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [FRAME_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    frame_setting = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Most references come from a working set a little larger than the stack, so hits,
  // appends and evictions all occur; the rest are random pages or the all-zero and all-one pages.
  task automatic queue_random_references(input int count);
    logic [PAGE_W-1:0] working_set [$];
    int                span;
    int                pick;
    span = ((effective_frames() > occupied) ? effective_frames() : occupied)
           + $urandom_range(1, 4);
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        working_set.delete();
        for (int j = 0; j < span; j++) working_set.push_back(PAGE_W'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        page_q.push_back(working_set[$urandom_range(0, span - 1)]);
      end else if (pick < 96) begin
        page_q.push_back(PAGE_W'($urandom));
      end else begin
        page_q.push_back((pick % 2) ? '1 : '0);
      end
    end
  endtask

  int unsigned settings [] = '{8, 16, 31, 32, 63, 1, 0, 2, 33, 5, 3, 4};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.page_number = '0;
    out_ch.ready = 1'b1;
    for (int i = 0; i < FRAMES; i++) resident_pages[i] = '0;
    occupied = 0;
    faults_total = '0;
    refs_total = '0;
    frame_setting = FRAME_COUNT_RESET;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the four reset frames, hit at the bottom, middle and top, then evict.
    page_q = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE, 16'h7FFE,
               16'hFFFF, 16'h1234, 16'h0000, 16'h8001, 16'h5555, 16'hAAAA,
               16'h5555, 16'h0001, 16'h8000, 16'hFFFF, 16'h0001, 16'hAAAA};
    wait_for_drain();

    foreach (settings[s]) begin
      write_frame_count(FRAME_W'(settings[s]));
      queue_random_references(RANDOM_PER_SETTING);
      wait_for_drain();
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    $display("Checked %0d references over %0d frame settings: %0d hits, %0d evictions.",
             checked_count, settings.size() + 1, hit_count, evict_count);
    $display("Frame counts ran from 0 to 63, including lowering below the resident pages.");
    if (mismatch_count == 0) begin
      $display("lru_page_replacement verification clean");
    end else begin
      $display("lru_page_replacement verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lrupr_pkg.sv
rtl/lrupr_if.sv
rtl/lrupr_cell.sv
rtl/lru_page_replacement.sv
sim/tb.sv
